// ----- rtl/core/wpm_pkg.sv -----
// wpm_pkg: shared constants for the window percentile mid-level core
// register codes, field widths, defaults and the divide-by-100 reciprocal
// no dependencies
package wpm_pkg;

  localparam int WindowMaxDef  = 1024;
  localparam int SampleBitsDef = 16;

  localparam int CfgDataW = 11;
  localparam int WsW      = 11;
  localparam int OvW      = 10;
  localparam int CfgIdxW  = 1;

  localparam logic [CfgIdxW-1:0] CfgWindowSize = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgOverlap    = 1'b1;

  localparam logic [WsW-1:0] WsReset = 11'd1024;
  localparam logic [OvW-1:0] OvReset = 10'd0;

  // floor(x/100) == (x * RecipMul) >> RecipShift for x below 2^17
  localparam int RecipShift = 24;
  localparam int RecipMulW  = 18;
  localparam logic [RecipMulW-1:0] RecipMul = 18'd167773;

endpackage

// ----- rtl/core/window_percentile_midlevel_core.sv -----
// window_percentile_midlevel_core: sliding-window percentile levels and midpoint
// one window memory, bitwise radix selection of two order statistics, overlap copy
// depends on wpm_pkg
//
//  channel   ports                                        direction
//  sample    start, busy, sample_i                        in
//  result    valid_o, mid_level_x2_o, low_level_o,        out
//            high_level_o
//  config    cfg_we_i, cfg_idx_i, cfg_wdata_i             in
//
// a sample that does not complete a window is only stored; busy stays low
// a completing sample then holds busy through the prep state, one read pass over the memory
// per result bit, and the overlap copy when ov is nonzero
// result is a one-cycle strobe at the end of the last pass; the receiver cannot stall it
// no clearing pass after reset; the window memory is never read before written
module window_percentile_midlevel_core #(
  parameter int WINDOW_MAX  = wpm_pkg::WindowMaxDef,
  parameter int SAMPLE_BITS = wpm_pkg::SampleBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [SAMPLE_BITS-1:0]     sample_i,
  input  logic                              cfg_we_i,
  input  logic [wpm_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [wpm_pkg::CfgDataW-1:0]      cfg_wdata_i,
  output logic                              valid_o,
  output logic signed [SAMPLE_BITS:0]       mid_level_x2_o,
  output logic signed [SAMPLE_BITS-1:0]     low_level_o,
  output logic signed [SAMPLE_BITS-1:0]     high_level_o
);

  localparam int AW   = (WINDOW_MAX > 2) ? $clog2(WINDOW_MAX) : 1;
  localparam int CntW = $clog2(WINDOW_MAX + 1);
  localparam int ExtW = (CntW > wpm_pkg::WsW) ? CntW : wpm_pkg::WsW;
  localparam int BW   = $clog2(SAMPLE_BITS);
  localparam int PW   = ExtW + wpm_pkg::RecipMulW;

  localparam logic [SAMPLE_BITS-1:0] SignBit = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [1:0] {Idle, Prep, Scan, Copy} state_e;

  state_e state_q;

  logic [wpm_pkg::WsW-1:0] cfg_ws_q;
  logic [wpm_pkg::OvW-1:0] cfg_ov_q;
  logic [CntW-1:0]         fill_q;
  logic [CntW-1:0]         ws_q, ov_q;
  logic [CntW-1:0]         k_lo_q, k_hi_q, cnt_lo_q, cnt_hi_q;
  logic [SAMPLE_BITS-1:0]  pref_lo_q, pref_hi_q;
  logic [BW-1:0]           bit_q;
  logic [AW-1:0]           rd_addr_q, cp_wa_q;
  logic                    issue_q, vld_q, last_q;
  logic [SAMPLE_BITS-1:0]  rdata_q;

  logic [SAMPLE_BITS-1:0]  mem [WINDOW_MAX];

  // effective window and overlap from the registers
  logic [ExtW-1:0] ws_ext, ov_ext, ws_eff, fill_ext, pos_ext;
  always_comb begin
    ws_ext   = ExtW'(cfg_ws_q);
    ov_ext   = ExtW'(cfg_ov_q);
    fill_ext = ExtW'(fill_q);
    if (ws_ext < ExtW'(2))                ws_eff = ExtW'(2);
    else if (ws_ext > ExtW'(WINDOW_MAX))  ws_eff = ExtW'(WINDOW_MAX);
    else                                  ws_eff = ws_ext;
    if (fill_ext > ws_eff - ExtW'(1))     pos_ext = ws_eff - ExtW'(1);
    else                                  pos_ext = fill_ext;
  end

  logic [ExtW-1:0] ov_eff;
  assign ov_eff = (ov_ext > ws_eff - ExtW'(1)) ? ws_eff - ExtW'(1) : ov_ext;

  logic accept;
  assign accept = start && (state_q == Idle);
  assign busy   = (state_q != Idle);

  // low rank index ws/100 via reciprocal; high rank index ws minus it, or ws - 1 when it is zero
  logic [PW-1:0]   prod;
  logic [CntW-1:0] lo_idx, hi_idx;
  always_comb begin
    prod   = PW'(ws_q) * PW'(wpm_pkg::RecipMul);
    lo_idx = CntW'(prod >> wpm_pkg::RecipShift);
    hi_idx = (lo_idx == '0) ? ws_q - CntW'(1) : ws_q - lo_idx;
  end

  // bit match against the prefix decided so far
  logic [SAMPLE_BITS-1:0] key, hi_mask;
  logic                   m_lo, m_hi;
  logic [CntW-1:0]        cnt_lo_n, cnt_hi_n;
  always_comb begin
    key      = rdata_q ^ SignBit;
    hi_mask  = {SAMPLE_BITS{1'b1}} << ({1'b0, bit_q} + 1'b1);
    m_lo     = (((key ^ pref_lo_q) & hi_mask) == '0) && !key[bit_q];
    m_hi     = (((key ^ pref_hi_q) & hi_mask) == '0) && !key[bit_q];
    cnt_lo_n = cnt_lo_q + CntW'(m_lo);
    cnt_hi_n = cnt_hi_q + CntW'(m_hi);
  end

  // memory port control
  logic                   rd_en, mem_we;
  logic [AW-1:0]          rd_addr, mem_wa;
  logic [SAMPLE_BITS-1:0] mem_wd;
  logic [CntW-1:0]        cp_src;
  always_comb begin
    cp_src  = ws_q - ov_q + CntW'(rd_addr_q);
    rd_en   = issue_q && ((state_q == Scan) || (state_q == Copy));
    rd_addr = (state_q == Copy) ? AW'(cp_src) : rd_addr_q;
    mem_we  = accept || ((state_q == Copy) && vld_q);
    mem_wa  = accept ? AW'(pos_ext) : cp_wa_q;
    mem_wd  = accept ? sample_i : rdata_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (rd_en)  rdata_q <= mem[rd_addr];
  end

  logic [SAMPLE_BITS-1:0] lo_fin, hi_fin;
  always_comb begin
    lo_fin = pref_lo_q;
    hi_fin = pref_hi_q;
    if (!(k_lo_q < cnt_lo_n)) lo_fin[bit_q] = 1'b1;
    if (!(k_hi_q < cnt_hi_n)) hi_fin[bit_q] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= Idle;
      cfg_ws_q       <= wpm_pkg::WsReset;
      cfg_ov_q       <= wpm_pkg::OvReset;
      fill_q         <= '0;
      ws_q           <= '0;
      ov_q           <= '0;
      issue_q        <= 1'b0;
      vld_q          <= 1'b0;
      last_q         <= 1'b0;
      valid_o        <= 1'b0;
      rd_addr_q      <= '0;
      cp_wa_q        <= '0;
      bit_q          <= '0;
      k_lo_q         <= '0;
      k_hi_q         <= '0;
      cnt_lo_q       <= '0;
      cnt_hi_q       <= '0;
      pref_lo_q      <= '0;
      pref_hi_q      <= '0;
      mid_level_x2_o <= '0;
      low_level_o    <= '0;
      high_level_o   <= '0;
    end else begin
      valid_o <= 1'b0;
      vld_q   <= rd_en;
      last_q  <= rd_en && (CntW'(rd_addr_q) ==
                 ((state_q == Copy) ? ov_q - CntW'(1) : ws_q - CntW'(1)));
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          wpm_pkg::CfgWindowSize: cfg_ws_q <= cfg_wdata_i;
          wpm_pkg::CfgOverlap:    cfg_ov_q <= cfg_wdata_i[wpm_pkg::OvW-1:0];
          default: ;
        endcase
      end
      if (rd_en) begin
        if (CntW'(rd_addr_q) ==
            ((state_q == Copy) ? ov_q - CntW'(1) : ws_q - CntW'(1))) begin
          issue_q <= 1'b0;
        end else begin
          rd_addr_q <= rd_addr_q + AW'(1);
        end
      end
      unique case (state_q)
        Idle: begin
          if (accept) begin
            if (pos_ext + ExtW'(1) >= ws_eff) begin
              ws_q    <= CntW'(ws_eff);
              ov_q    <= CntW'(ov_eff);
              state_q <= Prep;
            end else begin
              fill_q <= CntW'(pos_ext + ExtW'(1));
            end
          end
        end
        Prep: begin
          k_lo_q    <= lo_idx;
          k_hi_q    <= hi_idx;
          cnt_lo_q  <= '0;
          cnt_hi_q  <= '0;
          pref_lo_q <= '0;
          pref_hi_q <= '0;
          bit_q     <= BW'(SAMPLE_BITS - 1);
          rd_addr_q <= '0;
          issue_q   <= 1'b1;
          state_q   <= Scan;
        end
        Scan: begin
          if (vld_q) begin
            if (last_q) begin
              pref_lo_q <= lo_fin;
              pref_hi_q <= hi_fin;
              if (!(k_lo_q < cnt_lo_n)) k_lo_q <= k_lo_q - cnt_lo_n;
              if (!(k_hi_q < cnt_hi_n)) k_hi_q <= k_hi_q - cnt_hi_n;
              cnt_lo_q <= '0;
              cnt_hi_q <= '0;
              rd_addr_q <= '0;
              if (bit_q == '0) begin
                valid_o        <= 1'b1;
                low_level_o    <= lo_fin ^ SignBit;
                high_level_o   <= hi_fin ^ SignBit;
                mid_level_x2_o <= (SAMPLE_BITS+1)'(signed'(lo_fin ^ SignBit))
                                + (SAMPLE_BITS+1)'(signed'(hi_fin ^ SignBit));
                if (ov_q == '0) begin
                  fill_q  <= '0;
                  state_q <= Idle;
                end else begin
                  issue_q <= 1'b1;
                  state_q <= Copy;
                end
              end else begin
                bit_q   <= bit_q - BW'(1);
                issue_q <= 1'b1;
              end
            end else begin
              cnt_lo_q <= cnt_lo_n;
              cnt_hi_q <= cnt_hi_n;
            end
          end
        end
        Copy: begin
          // each write lands in the cycle after its read; destination always below source
          if (rd_en) cp_wa_q <= rd_addr_q;
          if (vld_q && last_q) begin
            fill_q    <= ov_q;
            rd_addr_q <= '0;
            state_q   <= Idle;
          end
        end
        default: state_q <= Idle;
      endcase
    end
  end

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (low_level_o <= high_level_o))
    else $error("low level above high level");

  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(state_q) == Scan)
    else $error("result strobe outside selection");

  a_copy_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Copy && mem_we && rd_en) |-> (CntW'(mem_wa) < CntW'(rd_addr)))
    else $error("overlap copy overtook its source");

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(WINDOW_MAX))
    else $error("fill count beyond window memory");

endmodule

// ----- test/tb.sv -----
// tb: self-checking bench for window_percentile_midlevel_core
// predicts both order statistics and their sum per completed window; checks each result word
// depends on wpm_pkg and window_percentile_midlevel_core
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic signed [16:0] mid;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
  } levels_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic signed [15:0]           sample_i = '0;
  logic                         cfg_we_i = 1'b0;
  logic [wpm_pkg::CfgIdxW-1:0]  cfg_idx_i = wpm_pkg::CfgWindowSize;
  logic [wpm_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic                         valid_o;
  logic signed [16:0]           mid_level_x2_o;
  logic signed [15:0]           low_level_o;
  logic signed [15:0]           high_level_o;

  logic signed [15:0] sample_q[$];
  levels_t            levels_q[$];
  int                 errors = 0;
  int                 gap_left = 0;
  bit                 quiet_sender = 1'b0;

  // model of the block state
  int win_mem[1024];
  int fill_cnt = 0;
  int ws_reg = 1024;
  int ov_reg = 0;

  window_percentile_midlevel_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .sample_i(sample_i),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i),
    .valid_o(valid_o), .mid_level_x2_o(mid_level_x2_o), .low_level_o(low_level_o),
    .high_level_o(high_level_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic take_sample(input logic signed [15:0] s);
    int ws, ov, pos, lo_i, hi_i, key, j;
    int srt[1024];
    levels_t lv;
    ws = (ws_reg < 2) ? 2 : (ws_reg > 1024) ? 1024 : ws_reg;
    pos = (fill_cnt > ws - 1) ? ws - 1 : fill_cnt;
    win_mem[pos] = s;
    fill_cnt = pos + 1;
    if (fill_cnt < ws) return;
    for (int i = 0; i < ws; i++) begin
      key = win_mem[i];
      j = i - 1;
      while (j >= 0 && srt[j] > key) begin
        srt[j+1] = srt[j];
        j--;
      end
      srt[j+1] = key;
    end
    lo_i = ws / 100;
    hi_i = ws - lo_i;
    if (hi_i > ws - 1) hi_i = ws - 1;
    lv.lo = 16'(srt[lo_i]);
    lv.hi = 16'(srt[hi_i]);
    lv.mid = 17'(srt[lo_i] + srt[hi_i]);
    levels_q.push_back(lv);
    // newest samples slide to the front of the next window
    ov = (ov_reg > ws - 1) ? ws - 1 : ov_reg;
    for (int i = 0; i < ov; i++) win_mem[i] = win_mem[ws - ov + i];
    fill_cnt = ov;
  endtask

  // sample driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        take_sample(sample_i);
        if (!quiet_sender && $urandom_range(0, 15) != 0) begin
          gap_left <= $urandom_range(0, 15);
          start <= 1'b0;
        end else if (sample_q.size() != 0) begin
          sample_i <= sample_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end else if (!start) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (sample_q.size() != 0) begin
          start <= 1'b1;
          sample_i <= sample_q.pop_front();
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    levels_t want;
    if (rst_ni && valid_o) begin
      if (levels_q.size() == 0) begin
        $error("unexpected result word mid=%0d lo=%0d hi=%0d",
               mid_level_x2_o, low_level_o, high_level_o);
        errors++;
      end else begin
        want = levels_q.pop_front();
        if (mid_level_x2_o !== want.mid) begin
          $error("mid_level_x2 expected %0d got %0d", want.mid, mid_level_x2_o);
          errors++;
        end
        if (low_level_o !== want.lo) begin
          $error("low_level expected %0d got %0d", want.lo, low_level_o);
          errors++;
        end
        if (high_level_o !== want.hi) begin
          $error("high_level expected %0d got %0d", want.hi, high_level_o);
          errors++;
        end
      end
    end
  end

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
      1, 2: return 16'($signed($urandom_range(0, 16)) - 8);  // many ties
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic drain();
    @(negedge clk_i);
    while (sample_q.size() != 0 || start || busy || levels_q.size() != 0) @(negedge clk_i);
    // overlap copy may still run after the last word
    repeat (1100) @(negedge clk_i);
    while (busy) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [wpm_pkg::CfgIdxW-1:0] idx, input int val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= wpm_pkg::CfgDataW'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == wpm_pkg::CfgWindowSize) ws_reg = val & 'h7ff;
    else ov_reg = val & 'h3ff;
  endtask

  task automatic set_window(input int ws, input int ov);
    drain();
    write_reg(wpm_pkg::CfgWindowSize, ws);
    write_reg(wpm_pkg::CfgOverlap, ov);
  endtask

  initial begin
    int sent, ws, ov, n;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, clamped sizes and overlap
    set_window(2, 0);
    quiet_sender = 1'b1;
    sample_q = '{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                 16'sh8000, 16'sh8000, 16'sh0000, -16'sd1};
    set_window(0, 1023);
    quiet_sender = 1'b0;
    sample_q = '{16'sh5555, 16'shaaaa, 16'sd1};
    set_window(1, 5);
    sample_q = '{16'sh7fff, 16'sh8000, 16'sd3};
    set_window(5, 3);
    sample_q = '{16'sd9, -16'sd9, 16'sd0, 16'sd4, 16'sh7fff, 16'sh8000, 16'sd2};
    // shrink while a partial window is held
    set_window(3, 2);
    sample_q = '{16'sd100, 16'sd200};
    sent = 23;

    // largest window, then shrink from a deep fill
    set_window(2047, 1000);
    for (int i = 0; i < 1050; i++) sample_q.push_back(rand_sample());
    sent += 1050;

    while (sent < 1700) begin
      if ($urandom_range(0, 9) < 7) begin
        ws = $urandom_range(2, 40);
        ov = ($urandom_range(0, 4) == 0) ? 1023 : $urandom_range(0, ws - 1);
      end else begin
        ws = $urandom_range(90, 300);
        ov = $urandom_range(0, ws / 2);
      end
      n = $urandom_range(40, 120);
      set_window(ws, ov);
      quiet_sender = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n; i++) sample_q.push_back(rand_sample());
      sent += n;
    end
    drain();

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
